@@ src/tkss_pkg.sv @@
// ----------------------------------------------------------------------------
// tkss_pkg
// Shared sizes, the operation code and the cell control types of the sorted
// score table.
// ----------------------------------------------------------------------------
package tkss_pkg;

	localparam int CAPACITY   = 16;
	localparam int SCORE_BITS = 32;
	localparam int TAG_BITS   = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// control handed from the table control to one cell
	typedef struct packed {
		logic occ;      // cell holds a live entry
		logic at_end;   // cell is the first free slot
		logic wr_en;    // an insert that places is committed this cycle
		logic found_in; // an earlier cell already took the new score
	} cell_ctrl_t;

	// status handed from one cell to its right neighbor and the control
	typedef struct packed {
		logic here;  // the new score lands in this cell
		logic found; // the new score lands in this cell or earlier
	} cell_stat_t;

endpackage

@@ src/tkss_cell.sv @@
// ----------------------------------------------------------------------------
// tkss_cell
// One slot of the sorted chain: compares the new score with its own entry,
// then holds, loads the new entry or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module tkss_cell (
	input  logic                                 clk,
	input  tkss_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [tkss_pkg::SCORE_BITS-1:0] new_score,
	input  logic        [tkss_pkg::TAG_BITS-1:0]   new_tag,
	input  logic signed [tkss_pkg::SCORE_BITS-1:0] left_score,
	input  logic        [tkss_pkg::TAG_BITS-1:0]   left_tag,
	output tkss_pkg::cell_stat_t                 stat,
	output logic signed [tkss_pkg::SCORE_BITS-1:0] score_q,
	output logic        [tkss_pkg::TAG_BITS-1:0]   tag_q
);
	import tkss_pkg::*;

	logic hit;

	// strictly greater keeps equal scores in arrival order
	assign hit        = ctrl.occ && (new_score > score_q);
	assign stat.here  = !ctrl.found_in && (hit || ctrl.at_end);
	assign stat.found = ctrl.found_in || hit;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			if (stat.here) begin
				score_q <= new_score;
				tag_q   <= new_tag;
			end else if (ctrl.found_in) begin
				score_q <= left_score;
				tag_q   <= left_tag;
			end
		end
	end

endmodule

@@ src/top_k_sorted_score_table.sv @@
// ----------------------------------------------------------------------------
// top_k_sorted_score_table
// Descending sorted table of signed scores with tags, kept in a chain of
// compare-and-shift cells, with insert, read and clear requests.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    s_tuser op, s_tdata score/tag/index
// m_*       out        m_tvalid / m_tready    m_tdata result fields
// cfg_*     in         cfg_valid / cfg_ready  cfg_data max_entries
//
// For each request every cell compares the new score with its own entry in
// parallel, the found flag ripples down the chain, and all cells hold, load
// or shift in the same clock edge. The result is registered and appears in
// the cycle after acceptance. A new request is taken while the result register is
// empty or being drained, so the sustained rate is one request per cycle; a
// stalled m_tready holds the result and stalls s_tready. Reset clears the
// entry count, the result valid and sets max_entries to the capacity; slot
// contents are not reset and are never read before being written.
// ----------------------------------------------------------------------------
module top_k_sorted_score_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // score[31:0], tag[47:32], index[51:48], zero[55:52]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // placed[0], position[4:1], entry_valid[5],
	                               // entry_score[37:6], entry_tag[53:38],
	                               // top_score[85:54], entry_count[90:86], zero[95:91]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // max_entries[4:0]
);
	import tkss_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// request fields
	logic signed [SCORE_BITS-1:0] in_score;
	logic        [TAG_BITS-1:0]   in_tag;
	logic        [IDX_W-1:0]      in_index;
	op_t                          in_op;

	// state
	logic [CNT_W-1:0] count_q;
	logic [4:0]       max_q;
	logic             m_valid_q;
	logic [95:0]      m_data_q;

	// chain wiring
	cell_ctrl_t                   ctrl  [CAPACITY];
	cell_stat_t                   stat  [CAPACITY];
	logic signed [SCORE_BITS-1:0] slot_score [CAPACITY];
	logic        [TAG_BITS-1:0]   slot_tag   [CAPACITY];
	logic        [CAPACITY:0]     found;

	logic             accept;
	logic             do_insert;
	logic [CNT_W-1:0] lim;
	logic             placed_c;
	logic [IDX_W-1:0] pos_c;
	logic [CNT_W-1:0] count_nxt;
	logic             rd_valid;
	logic signed [SCORE_BITS-1:0] rd_score;
	logic        [TAG_BITS-1:0]   rd_tag;
	logic signed [SCORE_BITS-1:0] top_c;

	assign in_score = s_tdata[31:0];
	assign in_tag   = s_tdata[47:32];
	assign in_index = s_tdata[51:48];
	assign in_op    = op_t'(s_tuser);

	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign do_insert = accept && (in_op == OP_INSERT);
	assign cfg_ready = 1'b1;

	// out-of-range limit falls back to the full capacity
	assign lim = (max_q == 5'd0 || CNT_W'(max_q) > CAP_CNT) ? CAP_CNT : CNT_W'(max_q);

	// found flag ripples from the top-ranked cell down
	assign found[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ctrl[i].occ      = CNT_W'(i) < count_q;
		assign ctrl[i].at_end   = CNT_W'(i) == count_q;
		assign ctrl[i].wr_en    = do_insert && placed_c;
		assign ctrl[i].found_in = found[i];
		assign found[i+1]       = stat[i].found;

		if (i == 0) begin : g_head
			tkss_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[i]),
				.new_score  (in_score),
				.new_tag    (in_tag),
				.left_score (in_score),
				.left_tag   (in_tag),
				.stat       (stat[i]),
				.score_q    (slot_score[i]),
				.tag_q      (slot_tag[i])
			);
		end else begin : g_body
			tkss_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl[i]),
				.new_score  (in_score),
				.new_tag    (in_tag),
				.left_score (slot_score[i-1]),
				.left_tag   (slot_tag[i-1]),
				.stat       (stat[i]),
				.score_q    (slot_score[i]),
				.tag_q      (slot_tag[i])
			);
		end
	end

	// encode the one landing cell; drop the insert when it lands past the limit
	always_comb begin
		placed_c = 1'b0;
		pos_c    = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (stat[i].here) begin
				pos_c = pos_c | IDX_W'(i);
				if (CNT_W'(i) < lim) begin
					placed_c = 1'b1;
				end
			end
		end
	end

	// entry count after this request
	always_comb begin
		count_nxt = count_q;
		case (in_op)
			OP_INSERT: begin
				if (placed_c) begin
					count_nxt = (count_q + 1'b1 > lim) ? lim : count_q + 1'b1;
				end else if (count_q > lim) begin
					count_nxt = lim;
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	// read port and top score
	assign rd_valid = (in_op == OP_READ) && (CNT_W'(in_index) < count_q);
	assign rd_score = rd_valid ? slot_score[in_index] : '0;
	assign rd_tag   = rd_valid ? slot_tag[in_index] : '0;

	always_comb begin
		if (count_nxt == '0) begin
			top_c = '0;
		end else if (in_op == OP_INSERT && placed_c && stat[0].here) begin
			top_c = in_score;
		end else begin
			top_c = slot_score[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			max_q     <= 5'(CAPACITY);
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (accept) begin
				count_q   <= count_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload; hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {5'd0,
			             count_nxt,
			             top_c,
			             rd_tag,
			             rd_score,
			             rd_valid,
			             (in_op == OP_INSERT && placed_c) ? pos_c : {IDX_W{1'b0}},
			             (in_op == OP_INSERT) && placed_c};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
